// File: src/stpr_pkg.sv
// stpr_pkg: shared types, codes and helpers for the ramped stepper move block
// used by every module under src; depends on nothing

package stpr_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [2:0] ST_STEP    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_FAULT   = 3'd2;
  localparam logic [2:0] ST_WATER   = 3'd3;
  localparam logic [2:0] ST_LEFT    = 3'd4;
  localparam logic [2:0] ST_RIGHT   = 3'd5;
  localparam logic [2:0] ST_TIMEOUT = 3'd6;
  localparam logic [2:0] ST_IDLE    = 3'd7;

  localparam logic [1:0] CFG_FIRST_DELAY  = 2'd0;
  localparam logic [1:0] CFG_SECOND_DELAY = 2'd1;
  localparam logic [1:0] CFG_MAX_HITS     = 2'd2;

  localparam logic [15:0] DELAY_START_ADD = 16'd500;
  localparam logic [15:0] RAMP_FLOOR      = 16'd300;
  localparam logic [15:0] RAMP_CEIL       = 16'd2000;
  localparam logic [15:0] RAMP_DOWN       = 16'd3;
  localparam logic [15:0] RAMP_UP         = 16'd4;
  localparam logic [23:0] SHORT_PLAN      = 24'd300;
  localparam logic [24:0] STEP_MARGIN     = 25'd100;
  // floor(n/3) = (n * ceil(2^25/3)) >> 25 for any 24-bit n
  localparam logic [23:0] DIV3_RECIP      = 24'd11184811;

  typedef struct packed {
    logic        cmd;
    logic [23:0] expected_steps;
    logic        direction;
    logic        stop_fault;
    logic        water_down;
    logic        left_stop_debounced;
    logic        right_stop_debounced;
    logic        left_stop_raw;
    logic        right_stop_raw;
  } stpr_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pulse_delay_one;
    logic [15:0] pulse_delay_two;
  } stpr_out_t;

  typedef struct packed {
    logic [15:0] first_delay_preset;
    logic [15:0] second_delay_preset;
    logic [15:0] max_hits;
  } stpr_cfg_t;

  typedef struct packed {
    logic        moving;
    logic        move_direction;
    logic [24:0] step_count;
    logic [16:0] hit_count;
    logic [15:0] delay_one;
    logic [15:0] delay_two;
    logic [23:0] planned_steps;
    logic [22:0] third_of_plan;
  } stpr_state_t;

  function automatic logic [15:0] add_sat16(input logic [15:0] v, input logic [15:0] d);
    logic [16:0] s;
    s = {1'b0, v} + {1'b0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sub_sat16(input logic [15:0] v, input logic [15:0] d);
    return (v > d) ? (v - d) : 16'd0;
  endfunction

endpackage

// File: src/stepper_ramped_move_to_stop_top.sv
// stepper_ramped_move_to_stop_top: ramped stepper move toward an end stop
// depends on stpr_pkg, stpr_ctrl, stpr_out_stage
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_data  (stpr_in_t)
//   out     | output    | out_valid / out_stall | out_data (stpr_out_t)
//   cfg     | input     | cfg_we                | cfg_idx, cfg_data
//
// one item per cycle sustained while out_stall is low; an input transfer passes through
// the item register, the single-pass state update and the result register
// synchronous reset clears the move state, the presets and both valid flags
// out_stall holds the result and reaches in_stall in the same cycle when the item register is full

module stepper_ramped_move_to_stop_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stpr_pkg::stpr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stpr_pkg::stpr_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [15:0]         cfg_data
);
  import stpr_pkg::*;

  logic        in_v_r;
  logic        in_v_nxt;
  stpr_in_t    in_data_r;
  logic        in_xfer;
  logic        adv;
  stpr_state_t st_r;
  stpr_state_t st_nxt;
  stpr_cfg_t   cfg_r;
  stpr_out_t   res;

  assign adv      = in_v_r && (!out_valid || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_xfer) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIRST_DELAY:  cfg_r.first_delay_preset  <= cfg_data;
        CFG_SECOND_DELAY: cfg_r.second_delay_preset <= cfg_data;
        CFG_MAX_HITS:     cfg_r.max_hits            <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  stpr_ctrl u_ctrl (
    .item   (in_data_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  stpr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_hits_within_steps: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.moving |-> ({8'd0, st_r.hit_count} <= st_r.step_count))
    else $error("hit count ran ahead of step count");

  a_start_sets_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_data_r.cmd == CMD_START && res.status == ST_STEP) |=> st_r.moving)
    else $error("good start did not begin a move");

  a_idle_only_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.status == ST_IDLE) |-> !st_r.moving)
    else $error("idle status while a move runs");

  a_delays_zero_off_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_STEP) |->
      (out_data.pulse_delay_one == 16'd0 && out_data.pulse_delay_two == 16'd0))
    else $error("delays set on a non-step result");

endmodule

// File: src/stpr_ctrl.sv
// stpr_ctrl: single-pass next-state and result logic for one item
// depends on stpr_pkg

module stpr_ctrl (
  input  stpr_pkg::stpr_in_t    item,
  input  stpr_pkg::stpr_state_t st,
  input  stpr_pkg::stpr_cfg_t   cfg,
  output stpr_pkg::stpr_state_t st_nxt,
  output stpr_pkg::stpr_out_t   res
);
  import stpr_pkg::*;

  function automatic logic [31:0] ramp(input logic [23:0] planned, input logic [22:0] third,
                                       input logic [24:0] step, input logic [15:0] d1,
                                       input logic [15:0] d2);
    logic [23:0] far;
    logic [31:0] r;
    far = planned - {1'b0, third};
    r   = {d1, d2};
    if (planned > SHORT_PLAN) begin
      if ((step < {2'b00, third}) && (d1 > RAMP_FLOOR)) begin
        r = {sub_sat16(d1, RAMP_DOWN), sub_sat16(d2, RAMP_DOWN)};
      end else if ((step > {1'b0, far}) && (d1 < RAMP_CEIL)) begin
        r = {add_sat16(d1, RAMP_UP), add_sat16(d2, RAMP_UP)};
      end
    end
    return r;
  endfunction

  logic [47:0] prod;
  logic [22:0] third_new;
  logic [15:0] d1_start;
  logic [15:0] d2_start;
  logic [31:0] ramp_start;
  logic [24:0] step_inc;
  logic        pin;
  logic [16:0] hit_inc;
  logic        timed_out;
  logic        hits_over;
  logic        early_stop;
  logic [31:0] ramp_step;

  assign prod       = {24'd0, item.expected_steps} * {24'd0, DIV3_RECIP};
  assign third_new  = prod[47:25];
  assign d1_start   = add_sat16(cfg.first_delay_preset, DELAY_START_ADD);
  assign d2_start   = add_sat16(cfg.second_delay_preset, DELAY_START_ADD);
  assign ramp_start = ramp(item.expected_steps, third_new, 25'd0, d1_start, d2_start);

  assign step_inc   = st.step_count + 25'd1;
  assign pin        = st.move_direction ? item.right_stop_raw : item.left_stop_raw;
  assign hit_inc    = pin ? (st.hit_count + 17'd1) : st.hit_count;
  assign timed_out  = step_inc > ({1'b0, st.planned_steps} + STEP_MARGIN);
  assign hits_over  = hit_inc > {1'b0, cfg.max_hits};
  assign early_stop = ({1'b0, st.planned_steps} >= STEP_MARGIN) &&
                      (step_inc < ({1'b0, st.planned_steps} - STEP_MARGIN));
  assign ramp_step  = ramp(st.planned_steps, st.third_of_plan, step_inc,
                           st.delay_one, st.delay_two);

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (item.cmd == CMD_START) begin
      st_nxt.moving = 1'b0;
      priority if (item.stop_fault) begin
        res.status = ST_FAULT;
      end else if (!item.water_down) begin
        res.status = ST_WATER;
      end else if (item.left_stop_debounced) begin
        res.status = ST_LEFT;
      end else if (item.right_stop_debounced) begin
        res.status = ST_RIGHT;
      end else begin
        st_nxt.moving         = 1'b1;
        st_nxt.move_direction = item.direction;
        st_nxt.step_count     = '0;
        st_nxt.hit_count      = '0;
        st_nxt.planned_steps  = item.expected_steps;
        st_nxt.third_of_plan  = third_new;
        st_nxt.delay_one      = ramp_start[31:16];
        st_nxt.delay_two      = ramp_start[15:0];
        res.status            = ST_STEP;
        res.pulse_delay_one   = ramp_start[31:16];
        res.pulse_delay_two   = ramp_start[15:0];
      end
    end else if (!st.moving) begin
      res.status = ST_IDLE;
    end else begin
      st_nxt.step_count = step_inc;
      st_nxt.hit_count  = hit_inc;
      priority if (timed_out) begin
        st_nxt.moving = 1'b0;
        res.status    = ST_TIMEOUT;
      end else if (hits_over) begin
        st_nxt.moving = 1'b0;
        res.status    = early_stop ? ST_LEFT : ST_DONE;
      end else begin
        st_nxt.delay_one    = ramp_step[31:16];
        st_nxt.delay_two    = ramp_step[15:0];
        res.status          = ST_STEP;
        res.pulse_delay_one = ramp_step[31:16];
        res.pulse_delay_two = ramp_step[15:0];
      end
    end
  end

endmodule

// File: src/stpr_out_stage.sv
// stpr_out_stage: result register holding one transfer for the output channel
// depends on stpr_pkg

module stpr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  stpr_pkg::stpr_out_t res,
  input  logic                out_stall,
  output logic                out_valid,
  output stpr_pkg::stpr_out_t out_data
);
  import stpr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  stpr_out_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
